@@ hdl/mcrf_pkg.sv @@
// Shared constants, codes and helper functions for the multi-channel ring FIFO.
// Used by every module in this folder; depends on nothing.
package mcrf_pkg;

    localparam int CHANNELS    = 16;
    localparam int RING_SLOTS  = 8;
    localparam int STORE_DEPTH = CHANNELS * RING_SLOTS;

    localparam int OP_W    = 2;
    localparam int CH_W    = 4;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 6;
    localparam int KIND_W  = 3;
    localparam int FILL_W  = 3;
    localparam int PTR_W   = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(CHANNELS + 1);

    localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OPENED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WSTATUS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RBYTE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RNONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOFREE  = 3'd4;

    // Pointer table update request for one channel
    typedef struct packed {
        logic            clr;
        logic            wp_inc;
        logic            rp_inc;
        logic [CH_W-1:0] ch;
    } ptr_upd_t;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
        logic [FILL_W-1:0] diff;
        diff = FILL_W'(wp) - FILL_W'(rp);
        return (wp >= rp) ? diff : diff + FILL_W'(RING_SLOTS);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_W-1:0] ch,
                                                     input logic [PTR_W-1:0] p);
        return ADDR_W'(32'(ch) * RING_SLOTS + 32'(p));
    endfunction

endpackage

@@ hdl/mcrf_ring_ram.sv @@
// Byte store for all rings: one write port, one registered read port.
// Depends on mcrf_pkg for depth and widths.
module mcrf_ring_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [mcrf_pkg::ADDR_W-1:0] waddr,
    input  logic [mcrf_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [mcrf_pkg::ADDR_W-1:0] raddr,
    output logic [mcrf_pkg::BYTE_W-1:0] rdata
);
    import mcrf_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mcrf_ptr_table.sv @@
// Per-channel write and read pointers, cleared at reset and on channel open.
// Depends on mcrf_pkg for widths, ptr_upd_t and ptr_adv.
module mcrf_ptr_table (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mcrf_pkg::ptr_upd_t         upd,
    input  logic [mcrf_pkg::CH_W-1:0]  rd_ch,
    output logic [mcrf_pkg::PTR_W-1:0] wp,
    output logic [mcrf_pkg::PTR_W-1:0] rp
);
    import mcrf_pkg::*;

    logic [PTR_W-1:0] wp_reg [CHANNELS];
    logic [PTR_W-1:0] rp_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end else begin
            if (upd.clr) begin
                wp_reg[upd.ch] <= '0;
                rp_reg[upd.ch] <= '0;
            end else begin
                if (upd.wp_inc) begin
                    wp_reg[upd.ch] <= ptr_adv(wp_reg[upd.ch]);
                end
                if (upd.rp_inc) begin
                    rp_reg[upd.ch] <= ptr_adv(rp_reg[upd.ch]);
                end
            end
        end
    end

    assign wp = wp_reg[rd_ch];
    assign rp = rp_reg[rd_ch];

endmodule

@@ hdl/multi_channel_ring_fifo.sv @@
// Multi-channel ring FIFO: sixteen byte rings of eight slots behind one command channel.
// Depends on mcrf_pkg, mcrf_ptr_table and mcrf_ring_ram.
//
// Usage: the s_ channel carries one command word (open, write byte, read burst).
// The m_ channel returns result words; m_last marks the final word of a command.
// Open and write commands give one word; a read burst gives min(count, fill)
// byte words, or one read-nothing word.
// Timing: a command is taken when the block is idle, then executes in the
// EXEC state. Open and write finish there. A read burst starts the first ring
// RAM read in EXEC, then gives one byte per cycle from READ while the receiver does
// not stall, each following slot fetched through the single read port of the ring RAM.
// Results sit in an output register; the next command may be taken while the
// last word of the previous one waits there.
// Receiver stall: while m_ready is low and a word is held, execution holds
// and the RAM read data is kept; nothing is dropped.
// Reset: synchronous, active low; all channels closed, pointers zero, output
// empty. Ring contents are not cleared and need no clearing pass.
module multi_channel_ring_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mcrf_pkg::OP_W-1:0]   s_opcode,
    input  logic [mcrf_pkg::CH_W-1:0]   s_channel,
    input  logic [mcrf_pkg::BYTE_W-1:0] s_data_byte,
    input  logic [mcrf_pkg::REQ_W-1:0]  s_request_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mcrf_pkg::KIND_W-1:0] m_kind,
    output logic [mcrf_pkg::CH_W-1:0]   m_channel_out,
    output logic [mcrf_pkg::BYTE_W-1:0] m_read_byte,
    output logic                        m_accepted,
    output logic [mcrf_pkg::FILL_W-1:0] m_fill_level,
    output logic                        m_last
);
    import mcrf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [COUNT_W-1:0] nopen_reg, nopen_next;
    logic [OP_W-1:0]   op_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic              m_valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CH_W-1:0]   chout_reg, chout_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    logic              acc_reg, acc_next;
    logic [FILL_W-1:0] mfill_reg, mfill_next;
    logic              last_reg, last_next;
    logic              out_load;

    ptr_upd_t          upd;
    logic [PTR_W-1:0]  wp, rp;
    logic [FILL_W-1:0] cur_fill;
    logic [FILL_W-1:0] burst;
    logic              ch_open, load_ok, s_acc;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    mcrf_ptr_table u_ptr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .rd_ch   (ch_reg),
        .wp      (wp),
        .rp      (rp)
    );

    mcrf_ring_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (store_addr(ch_reg, wp)),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign load_ok  = !m_valid_reg || m_ready;
    assign ch_open  = COUNT_W'(ch_reg) < nopen_reg;
    assign cur_fill = fill_of(wp, rp);
    assign burst    = (REQ_W'(cur_fill) < req_reg) ? cur_fill : FILL_W'(req_reg);

    always_comb begin
        state_next = state_reg;
        nopen_next = nopen_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        out_load   = 1'b0;
        kind_next  = KIND_WSTATUS;
        chout_next = ch_reg;
        rbyte_next = '0;
        acc_next   = 1'b0;
        mfill_next = '0;
        last_next  = 1'b1;
        upd        = '{clr: 1'b0, wp_inc: 1'b0, rp_inc: 1'b0, ch: ch_reg};
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = store_addr(ch_reg, rp);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (op_reg)
                    OP_OPEN: begin
                        if (load_ok) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (nopen_reg >= COUNT_W'(CHANNELS)) begin
                                kind_next  = KIND_NOFREE;
                                chout_next = '0;
                            end else begin
                                kind_next  = KIND_OPENED;
                                chout_next = CH_W'(nopen_reg);
                                upd.clr    = 1'b1;
                                upd.ch     = CH_W'(nopen_reg);
                                nopen_next = nopen_reg + 1'b1;
                            end
                        end
                    end
                    OP_WRITE: begin
                        if (load_ok) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            kind_next  = KIND_WSTATUS;
                            if (ch_open) begin
                                if (cur_fill == FILL_W'(RING_SLOTS - 1)) begin
                                    mfill_next = cur_fill;   // full: drop the word
                                end else begin
                                    ram_we     = 1'b1;
                                    upd.wp_inc = 1'b1;
                                    acc_next   = 1'b1;
                                    mfill_next = cur_fill + 1'b1;
                                end
                            end
                        end
                    end
                    OP_READ: begin
                        if (ch_open && burst != '0) begin
                            ram_re     = 1'b1;
                            cnt_next   = burst;
                            fill_next  = cur_fill;
                            state_next = ST_READ;
                        end else if (load_ok) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            kind_next  = KIND_RNONE;
                            mfill_next = ch_open ? cur_fill : '0;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                if (load_ok) begin
                    out_load   = 1'b1;
                    kind_next  = KIND_RBYTE;
                    rbyte_next = ram_rdata;
                    mfill_next = fill_reg - 1'b1;
                    last_next  = (cnt_reg == FILL_W'(1));
                    upd.rp_inc = 1'b1;
                    cnt_next   = cnt_reg - 1'b1;
                    fill_next  = fill_reg - 1'b1;
                    if (cnt_reg == FILL_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        // fetch the following slot while this word goes out
                        ram_re    = 1'b1;
                        ram_raddr = store_addr(ch_reg, ptr_adv(rp));
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nopen_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nopen_reg <= nopen_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg   <= s_opcode;
            ch_reg   <= s_channel;
            data_reg <= s_data_byte;
            req_reg  <= s_request_count;
        end
        cnt_reg  <= cnt_next;
        fill_reg <= fill_next;
        if (out_load) begin
            kind_reg  <= kind_next;
            chout_reg <= chout_next;
            rbyte_reg <= rbyte_next;
            acc_reg   <= acc_next;
            mfill_reg <= mfill_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_channel_out = chout_reg;
    assign m_read_byte   = rbyte_reg;
    assign m_accepted    = acc_reg;
    assign m_fill_level  = mfill_reg;
    assign m_last        = last_reg;

`ifndef SYNTH
    a_burst_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (cnt_reg != '0))
        else $error("read burst state with zero count");

    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nopen_reg <= COUNT_W'(CHANNELS))
        else $error("open channel count beyond channel total");

    a_no_ram_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ring RAM read and write in the same cycle");

    a_byte_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_RBYTE) |-> (m_fill_level < FILL_W'(RING_SLOTS - 1)))
        else $error("read byte word reports impossible fill");
`endif

endmodule
